// ===== design/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, masked while in reset
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, masked while in reset
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the next cycle at every edge, reset included
`define CHK_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rcf_pkg.sv =====
// shared types, coefficients and helper functions of the color filter
package rcf_pkg;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_GRAY    = 3'd1,
        MODE_SEPIA   = 3'd2,
        MODE_CINEMA  = 3'd3,
        MODE_VINTAGE = 3'd4,
        MODE_WARM    = 3'd5,
        MODE_COOL    = 3'd6,
        MODE_BRIGHT  = 3'd7
    } mode_t;

    localparam logic REG_PRESET_MODE = 1'b0;
    localparam logic REG_BRIGHTNESS  = 1'b1;

    localparam int CFG_DATA_W = 9;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // q0.16 luma weights, sum is exactly 65536
    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    function automatic logic [7:0] luma_of(input rgb_t c);
        logic [25:0] acc;
        acc = 26'(c.r) * 26'(LUMA_WR) + 26'(c.g) * 26'(LUMA_WG)
            + 26'(c.b) * 26'(LUMA_WB);
        return acc[23:16];
    endfunction

    // add a signed delta and clamp to 0..255
    function automatic logic [7:0] sat_add(input logic [7:0] v,
                                           input logic signed [10:0] d);
        logic signed [11:0] s;
        s = $signed({4'b0000, v}) + $signed({d[10], d});
        if (s < 12'sd0)
            return 8'd0;
        else if (s > 12'sd255)
            return 8'd255;
        else
            return s[7:0];
    endfunction

endpackage

// ===== design/rcf_tone.sv =====
// stage one: per-preset tone transform (sepia sums, contrast, shifts, gray)
module rcf_tone (
    input  logic                clk,
    input  logic                en,
    input  rcf_pkg::mode_t      mode,
    input  logic signed [8:0]   offset,
    input  rcf_pkg::pixel_in_t  pix,
    output rcf_pkg::rgb_t       c_reg,
    output rcf_pkg::mode_t      mode_reg
);
    import rcf_pkg::*;

    function automatic logic [7:0] sepia_row(input rgb_t c, input logic [15:0] w0,
                                             input logic [15:0] w1,
                                             input logic [15:0] w2);
        logic [25:0] acc;
        acc = 26'(c.r) * 26'(w0) + 26'(c.g) * 26'(w1) + 26'(c.b) * 26'(w2);
        if (acc[25:16] > 10'd255)
            return 8'd255;
        else
            return acc[23:16];
    endfunction

    // floor(5*(v-128)/4)+128, clamped
    function automatic logic [7:0] contrast(input logic [7:0] v);
        logic signed [10:0] dv;
        logic signed [10:0] d5;
        dv = $signed({3'b000, v}) - 11'sd128;
        d5 = (dv <<< 2) + dv;
        return sat_add(8'd128, d5 >>> 2);
    endfunction

    rgb_t       src;
    rgb_t       c_next;
    rgb_t       sep;
    logic [7:0] y;
    logic signed [10:0] off_ext;

    always_comb
    begin
        src     = '{r: pix.red_in, g: pix.green_in, b: pix.blue_in};
        sep.r   = sepia_row(src, 16'd25756, 16'd50397, 16'd12386);
        sep.g   = sepia_row(src, 16'd22872, 16'd44958, 16'd11010);
        sep.b   = sepia_row(src, 16'd17826, 16'd34996, 16'd8585);
        y       = luma_of(src);
        off_ext = 11'(offset);
        c_next  = src;
        case (mode) inside
            MODE_GRAY:
                c_next = '{r: y, g: y, b: y};
            MODE_SEPIA, MODE_VINTAGE:
                c_next = sep;
            MODE_CINEMA:
            begin
                c_next.r = sat_add(contrast(src.r), 11'sd20);
                c_next.g = sat_add(contrast(src.g), 11'sd8);
                c_next.b = sat_add(contrast(src.b), -11'sd20);
            end
            MODE_WARM:
            begin
                c_next.r = sat_add(src.r, 11'sd20);
                c_next.g = sat_add(src.g, 11'sd8);
                c_next.b = sat_add(src.b, -11'sd20);
            end
            MODE_COOL:
            begin
                c_next.r = sat_add(src.r, -11'sd20);
                c_next.g = sat_add(src.g, 11'sd5);
                c_next.b = sat_add(src.b, 11'sd20);
            end
            MODE_BRIGHT:
            begin
                c_next.r = sat_add(src.r, off_ext);
                c_next.g = sat_add(src.g, off_ext);
                c_next.b = sat_add(src.b, off_ext);
            end
            default:
                c_next = src;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= c_next;
            mode_reg <= mode;
        end
    end

endmodule

// ===== design/rcf_luma.sv =====
// stage two: luma of the toned pixel
module rcf_luma (
    input  logic            clk,
    input  logic            en,
    input  rcf_pkg::rgb_t   c,
    input  rcf_pkg::mode_t  mode,
    output rcf_pkg::rgb_t   c_reg,
    output logic [7:0]      y_reg,
    output rcf_pkg::mode_t  mode_reg
);
    import rcf_pkg::*;

    logic [7:0] y_next;

    assign y_next = luma_of(c);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= c;
            y_reg    <= y_next;
            mode_reg <= mode;
        end
    end

endmodule

// ===== design/rcf_blend.sv =====
// stage three: blend toward luma for cinematic (dark pixels) and vintage
module rcf_blend (
    input  logic            clk,
    input  logic            en,
    input  rcf_pkg::rgb_t   c,
    input  logic [7:0]      y,
    input  rcf_pkg::mode_t  mode,
    output rcf_pkg::rgb_t   c_reg,
    output rcf_pkg::mode_t  mode_reg
);
    import rcf_pkg::*;

    function automatic logic [7:0] mix(input logic [7:0] v, input logic [7:0] l,
                                       input logic [15:0] wc, input logic [15:0] wy);
        logic [24:0] acc;
        acc = 25'(v) * 25'(wc) + 25'(l) * 25'(wy);
        return acc[23:16];
    endfunction

    logic        blend_en;
    logic [15:0] wc;
    logic [15:0] wy;
    rgb_t        c_next;

    always_comb
    begin
        blend_en = 1'b0;
        wc       = 16'd55706;
        wy       = 16'd9830;
        if (mode == MODE_CINEMA)
            blend_en = (y < 8'd80);
        else if (mode == MODE_VINTAGE)
        begin
            blend_en = 1'b1;
            wc       = 16'd45875;
            wy       = 16'd19661;
        end
        c_next = c;
        if (blend_en)
        begin
            c_next.r = mix(c.r, y, wc, wy);
            c_next.g = mix(c.g, y, wc, wy);
            c_next.b = mix(c.b, y, wc, wy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= c_next;
            mode_reg <= mode;
        end
    end

endmodule

// ===== design/rcf_grain.sv =====
// stage four: vintage grain offset and output register
module rcf_grain (
    input  logic                clk,
    input  logic                en,
    input  rcf_pkg::rgb_t       c,
    input  rcf_pkg::mode_t      mode,
    output rcf_pkg::pixel_out_t pix_reg
);
    import rcf_pkg::*;

    logic [3:0]         nib;
    logic signed [10:0] noise;
    pixel_out_t         pix_next;

    always_comb
    begin
        nib      = c.r[3:0] ^ c.g[3:0] ^ c.b[3:0];
        noise    = $signed({7'd0, nib}) - 11'sd8;
        pix_next = '{red_out: c.r, green_out: c.g, blue_out: c.b};
        if (mode == MODE_VINTAGE)
        begin
            pix_next.red_out   = sat_add(c.r, noise);
            pix_next.green_out = sat_add(c.g, noise);
            pix_next.blue_out  = sat_add(c.b, noise);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pix_reg <= pix_next;
    end

endmodule

// ===== design/rgb_color_filter_presets.sv =====
// top level of the rgb888 preset color filter
// Filters one RGB888 pixel per transaction under the preset held in
// preset_mode (register 0); brightness_offset (register 1) feeds the
// brightness preset. Write registers only while no pixel is in flight.
// The datapath is a four-stage pipeline: tone transform, luma, luma blend,
// grain offset into the output register. A pixel enters every clock while
// the sink keeps out_ready high, and its result leaves from the grain
// register once it has passed the tone, luma and blend registers. Each stage
// has its own valid bit and advances when it is empty or the stage after it
// advances, so a stalled sink fills the empty stages first before in_ready
// drops; throughput is one transaction per cycle while out_ready is high.
module rgb_color_filter_presets (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [rcf_pkg::CFG_DATA_W-1:0]      cfg_data,
    // pixel input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rcf_pkg::pixel_in_t                  in_data,
    // pixel output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output rcf_pkg::pixel_out_t                 out_data
);
    import rcf_pkg::*;

    // configuration registers
    mode_t             mode_reg;
    logic signed [8:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESET_MODE: mode_reg   <= mode_t'(cfg_data[2:0]);
                REG_BRIGHTNESS:  offset_reg <= $signed(cfg_data[8:0]);
                default:         ;
            endcase
        end
    end

    // per-stage valid bits
    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [3:0] adv;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[3] = !valid_reg[3] || out_ready;
        adv[2] = !valid_reg[2] || adv[3];
        adv[1] = !valid_reg[1] || adv[2];
        adv[0] = !valid_reg[0] || adv[1];
        valid_next[0] = adv[0] ? in_valid     : valid_reg[0];
        valid_next[1] = adv[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = adv[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = adv[3] ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[3];

    // datapath stages
    rgb_t       c1;
    rgb_t       c2;
    rgb_t       c3;
    logic [7:0] y2;
    mode_t      m1;
    mode_t      m2;
    mode_t      m3;

    rcf_tone u_tone (
        .clk      (clk),
        .en       (adv[0]),
        .mode     (mode_reg),
        .offset   (offset_reg),
        .pix      (in_data),
        .c_reg    (c1),
        .mode_reg (m1)
    );

    rcf_luma u_luma (
        .clk      (clk),
        .en       (adv[1]),
        .c        (c1),
        .mode     (m1),
        .c_reg    (c2),
        .y_reg    (y2),
        .mode_reg (m2)
    );

    rcf_blend u_blend (
        .clk      (clk),
        .en       (adv[2]),
        .c        (c2),
        .y        (y2),
        .mode     (m2),
        .c_reg    (c3),
        .mode_reg (m3)
    );

    rcf_grain u_grain (
        .clk     (clk),
        .en      (adv[3]),
        .c       (c3),
        .mode    (m3),
        .pix_reg (out_data)
    );

endmodule

// ===== design/rcf_checker.sv =====
// port-level checker for the color filter, bound to the top level
`include "assert_macros.svh"

module rcf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rcf_pkg::pixel_out_t out_data
);
    import rcf_pkg::*;

    // no result is offered in the cycle after reset is seen
    `CHK_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "out_valid during reset")
    // a ready sink never back-pressures the source
    `CHK_SAME(a_no_stall, out_ready, in_ready, "in_ready low with sink ready")
    // a stalled result stays offered
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    // and keeps its payload
    `CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")

endmodule

bind rgb_color_filter_presets rcf_checker u_rcf_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench for the rgb888 preset color filter
module tb;
    import rcf_pkg::*;

    // q0.16 weights of luma, sepia rows and the two luma blends
    localparam int LUMA_R = 19595;
    localparam int LUMA_G = 38470;
    localparam int LUMA_B = 7471;
    localparam int SEPIA_RR = 25756;
    localparam int SEPIA_RG = 50397;
    localparam int SEPIA_RB = 12386;
    localparam int SEPIA_GR = 22872;
    localparam int SEPIA_GG = 44958;
    localparam int SEPIA_GB = 11010;
    localparam int SEPIA_BR = 17826;
    localparam int SEPIA_BG = 34996;
    localparam int SEPIA_BB = 8585;
    localparam int CINE_KEEP = 55706;
    localparam int CINE_LUMA = 9830;
    localparam int VINT_KEEP = 45875;
    localparam int VINT_LUMA = 19661;
    // cinematic blends toward luma only below this level
    localparam int CINE_DARK = 80;
    localparam int NOISE_MASK = 15;
    localparam int NOISE_BIAS = 8;

    localparam int PHASES = 17;
    localparam int PHASE_ITEMS = 100;
    // phase that runs with neither side idling
    localparam int STEADY_PHASE = 3;
    // phase in which the sender stops mid-way until the pipeline drains
    localparam int PAUSE_PHASE = 5;
    localparam int PIPE_DEPTH = 4;

    // tracks filter settings, predicts each pixel and compares results in order
    class pixel_scoreboard;
        pixel_out_t expected_q[$];
        mode_t      cur_mode;
        logic [8:0] cur_offset;
        int         errors;
        int         checked;

        function new();
            cur_mode   = MODE_NONE;
            cur_offset = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_config(logic idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PRESET_MODE)
                cur_mode = mode_t'(data[2:0]);
            else
                cur_offset = data[8:0];
        endfunction

        function int clamp8(int v);
            if (v < 0)
                return 0;
            if (v > 255)
                return 255;
            return v;
        endfunction

        function int luma(int c[3]);
            return (LUMA_R * c[0] + LUMA_G * c[1] + LUMA_B * c[2]) >> 16;
        endfunction

        function void shift_rgb(ref int c[3], input int dr, input int dg, input int db);
            c[0] = clamp8(c[0] + dr);
            c[1] = clamp8(c[1] + dg);
            c[2] = clamp8(c[2] + db);
        endfunction

        function void blend(ref int c[3], input int y, input int wk, input int wy);
            for (int i = 0; i < 3; i++)
                c[i] = ((c[i] * wk + y * wy) >> 16) & 255;
        endfunction

        function void sepia(ref int c[3]);
            int t[3];
            t[0] = (SEPIA_RR * c[0] + SEPIA_RG * c[1] + SEPIA_RB * c[2]) >> 16;
            t[1] = (SEPIA_GR * c[0] + SEPIA_GG * c[1] + SEPIA_GB * c[2]) >> 16;
            t[2] = (SEPIA_BR * c[0] + SEPIA_BG * c[1] + SEPIA_BB * c[2]) >> 16;
            for (int i = 0; i < 3; i++)
                c[i] = (t[i] > 255) ? 255 : t[i];
        endfunction

        function pixel_out_t filter_pixel(pixel_in_t px);
            int c[3];
            int y;
            int noise;
            int off;
            pixel_out_t res;
            c[0] = px.red_in;
            c[1] = px.green_in;
            c[2] = px.blue_in;
            case (cur_mode)
                MODE_GRAY:
                begin
                    y = luma(c);
                    c[0] = y;
                    c[1] = y;
                    c[2] = y;
                end
                MODE_SEPIA:
                    sepia(c);
                MODE_CINEMA:
                begin
                    // contrast about mid-gray, arithmetic shift gives the floor
                    for (int i = 0; i < 3; i++)
                        c[i] = clamp8(((5 * (c[i] - 128)) >>> 2) + 128);
                    shift_rgb(c, 20, 8, -20);
                    y = luma(c);
                    if (y < CINE_DARK)
                        blend(c, y, CINE_KEEP, CINE_LUMA);
                end
                MODE_VINTAGE:
                begin
                    sepia(c);
                    y = luma(c);
                    blend(c, y, VINT_KEEP, VINT_LUMA);
                    noise = ((c[0] ^ c[1] ^ c[2]) & NOISE_MASK) - NOISE_BIAS;
                    shift_rgb(c, noise, noise, noise);
                end
                MODE_WARM:
                    shift_rgb(c, 20, 8, -20);
                MODE_COOL:
                    shift_rgb(c, -20, 5, 20);
                MODE_BRIGHT:
                begin
                    off = int'($signed(cur_offset));
                    shift_rgb(c, off, off, off);
                end
                default:
                    ;
            endcase
            res.red_out   = c[0][7:0];
            res.green_out = c[1][7:0];
            res.blue_out  = c[2][7:0];
            return res;
        endfunction

        function void note_input(pixel_in_t px);
            expected_q.push_back(filter_pixel(px));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(pixel_out_t got);
            pixel_out_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected pixel %h", got));
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.red_out !== exp.red_out)
                report($sformatf("red got %h want %h", got.red_out, exp.red_out));
            if (got.green_out !== exp.green_out)
                report($sformatf("green got %h want %h", got.green_out, exp.green_out));
            if (got.blue_out !== exp.blue_out)
                report($sformatf("blue got %h want %h", got.blue_out, exp.blue_out));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pixel_in_t             in_data;
    logic                  out_valid;
    logic                  out_ready;
    pixel_out_t            out_data;

    pixel_scoreboard sb;
    // when set, neither the sender nor the sink idles
    bit steady;
    int settings_run;

    rgb_color_filter_presets u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the pipeline hangs
    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    // sink: back-pressure about a third of the time, never in the steady phase
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    // every output transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // channel value biased toward the clamp limits and dark tones
    function automatic logic [7:0] pick_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        if (r < 4)
            return 8'($urandom_range(0, 90));
        return 8'($urandom_range(0, 255));
    endfunction

    // present one pixel and hold it until the transaction completes
    task send_pixel(pixel_in_t px);
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = px;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(px);
    endtask

    // drop valid for a short random gap
    task sender_gap();
        int n;
        n = $urandom_range(1, 3);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending and wait for every predicted pixel to come out
    task drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.set_config(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // registers change only with the pipeline empty
    task apply_settings(mode_t mode, logic [8:0] offset);
        logic [CFG_DATA_W-1:0] d;
        drain();
        d = 9'($urandom);
        // upper bits of the mode write carry junk, only the low three count
        d[2:0] = mode;
        write_reg(REG_PRESET_MODE, d);
        write_reg(REG_BRIGHTNESS, offset);
        settings_run++;
    endtask

    task run_phase(int items, bit pause_mid);
        pixel_in_t px;
        for (int i = 0; i < items; i++)
        begin
            if (!steady && $urandom_range(0, 99) < 33)
                sender_gap();
            if (pause_mid && i == items / 2)
                drain();
            px.red_in   = pick_channel();
            px.green_in = pick_channel();
            px.blue_in  = pick_channel();
            send_pixel(px);
        end
    endtask

    initial
    begin
        mode_t      mode;
        logic [8:0] offset;
        logic [8:0] bright_offsets[6];
        pixel_in_t  directed_px[3];

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_PRESET_MODE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        steady    = 1'b0;
        settings_run = 0;
        sb = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: black, white and a mixed pixel under each fixed preset
        directed_px[0] = 24'h000000;
        directed_px[1] = 24'hffffff;
        directed_px[2] = 24'h1050f0;
        for (int m = 0; m < 7; m++)
        begin
            apply_settings(mode_t'(m), 9'h000);
            for (int k = 0; k < 3; k++)
                send_pixel(directed_px[k]);
        end
        // brightness at the largest offset and at the pattern that reads as -256
        apply_settings(MODE_BRIGHT, 9'h0ff);
        send_pixel(24'h8000ff);
        apply_settings(MODE_BRIGHT, 9'h100);
        send_pixel(24'hff7f00);

        // random phases: every preset, then brightness at its extremes, then a mix
        bright_offsets = '{9'h0ff, 9'h101, 9'h100, 9'h000, 9'h001, 9'h1ff};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 8)
            begin
                mode   = mode_t'(ph);
                offset = 9'($urandom_range(0, 511));
            end
            else if (ph < 14)
            begin
                mode   = MODE_BRIGHT;
                offset = bright_offsets[ph - 8];
            end
            else
            begin
                mode   = mode_t'($urandom_range(0, 7));
                offset = 9'($urandom_range(0, 511));
            end
            apply_settings(mode, offset);
            steady = (ph == STEADY_PHASE);
            run_phase(PHASE_ITEMS, ph == PAUSE_PHASE);
            steady = 1'b0;
        end

        drain();
        repeat (PIPE_DEPTH * 2) @(posedge clk);

        $display("checked %0d filtered pixels across %0d register settings", sb.checked,
                 settings_run);
        $display("all eight presets exercised, brightness offsets at both limits");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
